// ===== design/bdlp_pkg.sv =====
// Shared types and constants for the button debounce and long-press block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bdlp_pkg;

  // Field widths fixed by the register map.
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned CfgIndexWidth = 2;

  // Defaults for the module parameters.
  localparam int unsigned DefNumButtons = 4;
  localparam int unsigned DefAgeWidth   = 16;

  // Register reset values.
  localparam logic [CfgDataWidth-1:0] DebounceTicksRst  = CfgDataWidth'(50);
  localparam logic [CfgDataWidth-1:0] LongPressTicksRst = CfgDataWidth'(1500);

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_DEBOUNCE_TICKS    = 2'd0,
    CFG_LONG_PRESS_TICKS  = 2'd1,
    CFG_LONG_PRESS_ENABLE = 2'd2
  } cfg_index_e;

  // Timing thresholds shared by all button cells.
  typedef struct packed {
    logic [CfgDataWidth-1:0] debounce_ticks;
    logic [CfgDataWidth-1:0] long_press_ticks;
  } thresholds_t;

  // Events reported by one button cell for one tick.
  typedef struct packed {
    logic short_press;
    logic long_press;
  } button_event_t;

endpackage

// ===== design/bdlp_button.sv =====
// Per-button debounce timer and hold tracker for one millisecond tick.
// Depends on bdlp_pkg for the threshold and event structs.
`timescale 1ns / 1ps

module bdlp_button
  import bdlp_pkg::*;
#(
  parameter int unsigned AGE_WIDTH = DefAgeWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          edge_i,
  input  logic          released_i,
  input  logic          long_en_i,
  input  thresholds_t   thr_i,
  output button_event_t evt_o
);

  localparam int unsigned CmpWidth =
      (AGE_WIDTH > CfgDataWidth) ? AGE_WIDTH : CfgDataWidth;

  logic                 pending_q, pending_d;
  logic                 hold_q, hold_d;
  logic [AGE_WIDTH-1:0] edge_age_q, edge_age_d;
  logic [AGE_WIDTH-1:0] hold_age_q, hold_age_d;

  logic [AGE_WIDTH-1:0] edge_age_inc, hold_age_inc;
  logic                 pending_armed;
  logic [AGE_WIDTH-1:0] edge_age_armed;
  logic                 debounce_done, long_done;

  // Ages saturate at all ones.
  assign edge_age_inc = (pending_q && (edge_age_q != '1)) ? edge_age_q + 1'b1 : edge_age_q;
  assign hold_age_inc = (hold_q && (hold_age_q != '1)) ? hold_age_q + 1'b1 : hold_age_q;

  // A new edge re-arms the pending timer after ageing.
  assign pending_armed  = pending_q | edge_i;
  assign edge_age_armed = edge_i ? '0 : edge_age_inc;

  assign debounce_done = CmpWidth'(edge_age_armed) >= CmpWidth'(thr_i.debounce_ticks);
  assign long_done     = CmpWidth'(hold_age_inc) >= CmpWidth'(thr_i.long_press_ticks);

  always_comb begin
    pending_d   = pending_armed;
    edge_age_d  = edge_age_armed;
    hold_d      = hold_q;
    hold_age_d  = hold_age_inc;
    evt_o       = '0;
    if (hold_q) begin
      // The pending timer keeps ageing while a hold is in progress, but is not resolved.
      if (long_done) begin
        hold_d         = 1'b0;
        evt_o.long_press = 1'b1;
      end else if (released_i) begin
        hold_d          = 1'b0;
        evt_o.short_press = 1'b1;
      end
    end else if (pending_armed && debounce_done) begin
      pending_d = 1'b0;
      if (!released_i) begin
        if (long_en_i) begin
          hold_d     = 1'b1;
          hold_age_d = edge_age_armed;
        end else begin
          evt_o.short_press = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= 1'b0;
      hold_q     <= 1'b0;
      edge_age_q <= '0;
      hold_age_q <= '0;
    end else if (step_i) begin
      pending_q  <= pending_d;
      hold_q     <= hold_d;
      edge_age_q <= edge_age_d;
      hold_age_q <= hold_age_d;
    end
  end

endmodule

// ===== design/button_debounce_long_press.sv =====
// Top level of the button debounce and long-press decoder.
// Depends on bdlp_pkg and instantiates one bdlp_button per button.
`timescale 1ns / 1ps
//
// Channel  | Handshake                | Payload
// ---------+--------------------------+---------------------------------------------
// in       | in_valid_i / in_ready_o  | button_levels_i, falling_edges_i
// out      | out_valid_o / out_ready_i| short_press_mask_o, long_press_mask_o
// cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_wdata_i
//
// One tick transaction is accepted per clock cycle; its result transaction
// appears in the output register on the following cycle. Every button cell
// updates in parallel in that single cycle, so the sustained rate is one
// tick per cycle, limited only by the output register being taken.
// A tick is accepted whenever the output register is empty or is being
// emptied in the same cycle, so a stalled consumer blocks the input only
// while a result is actually waiting. Reset clears all per-button state and
// loads the register defaults; no clearing pass is needed afterwards.
// Configuration transactions are always accepted and take effect at once.

module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = DefNumButtons,
  parameter int unsigned AGE_WIDTH   = DefAgeWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Tick input channel.
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [NUM_BUTTONS-1:0]   button_levels_i,
  input  logic [NUM_BUTTONS-1:0]   falling_edges_i,
  // Result output channel.
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [NUM_BUTTONS-1:0]   short_press_mask_o,
  output logic [NUM_BUTTONS-1:0]   long_press_mask_o,
  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_wdata_i
);

  // Configuration registers.
  thresholds_t            thr_q;
  logic [NUM_BUTTONS-1:0] long_en_q;

  // Output register.
  logic                   out_valid_q;
  logic [NUM_BUTTONS-1:0] short_q, short_d;
  logic [NUM_BUTTONS-1:0] long_q, long_d;

  logic          step;
  button_event_t evt [NUM_BUTTONS];

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.debounce_ticks   <= DebounceTicksRst;
      thr_q.long_press_ticks <= LongPressTicksRst;
      long_en_q              <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DEBOUNCE_TICKS:    thr_q.debounce_ticks   <= cfg_wdata_i;
        CFG_LONG_PRESS_TICKS:  thr_q.long_press_ticks <= cfg_wdata_i;
        CFG_LONG_PRESS_ENABLE: long_en_q              <= cfg_wdata_i[NUM_BUTTONS-1:0];
        default: ;
      endcase
    end
  end

  // A tick may enter whenever the result register is free or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_button
    bdlp_button #(
      .AGE_WIDTH (AGE_WIDTH)
    ) u_button (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step),
      .edge_i     (falling_edges_i[b]),
      .released_i (button_levels_i[b]),
      .long_en_i  (long_en_q[b]),
      .thr_i      (thr_q),
      .evt_o      (evt[b])
    );
  end

  // Gather the per-button events into the two result masks.
  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      short_d[b] = evt[b].short_press;
      long_d[b]  = evt[b].long_press;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign short_press_mask_o = short_q;
  assign long_press_mask_o  = long_q;

endmodule

// ===== design/bdlp_checker.sv =====
// Port-level checks for the button debounce and long-press decoder.
// Depends on bdlp_pkg; bound to button_debounce_long_press below.
`timescale 1ns / 1ps

module bdlp_checker
  import bdlp_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = DefNumButtons
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [NUM_BUTTONS-1:0] short_press_mask_o,
  input logic [NUM_BUTTONS-1:0] long_press_mask_o
);

  // A waiting result is not withdrawn before it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // Every accepted tick yields a result on the next cycle.
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted tick produced no result");

  // No result appears without a tick having been accepted.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(in_valid_i && in_ready_o)) |=> !out_valid_o)
    else $error("result appeared without an accepted tick");

  // A button never reports a short and a long press in the same tick.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((short_press_mask_o & long_press_mask_o) == '0))
    else $error("short and long press reported together");

endmodule

bind button_debounce_long_press bdlp_checker #(
  .NUM_BUTTONS (NUM_BUTTONS)
) u_bdlp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .short_press_mask_o (short_press_mask_o),
  .long_press_mask_o  (long_press_mask_o)
);

// ===== verif/tb.sv =====
// Self-checking testbench for button_debounce_long_press: tick stimulus, a cycle model of the
// per-button debounce and hold timers, and a result checker on the output channel.
// Depends on bdlp_pkg and the design files of the block; nothing else is read.
`timescale 1ns / 1ps

module tb;
  import bdlp_pkg::*;

  localparam int NB     = DefNumButtons;
  localparam int AW     = DefAgeWidth;
  localparam int AGEMAX = (1 << AW) - 1;

  // One tick transaction as offered on the input channel.
  typedef struct packed {
    logic [NB-1:0] levels;
    logic [NB-1:0] edges;
  } tick_t;

  // One result transaction: the short and long press masks of a tick.
  typedef struct packed {
    logic [NB-1:0] short_m;
    logic [NB-1:0] long_m;
  } press_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [NB-1:0]            button_levels_i = '1;
  logic [NB-1:0]            falling_edges_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [NB-1:0]            short_press_mask_o;
  logic [NB-1:0]            long_press_mask_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0]  cfg_wdata_i = '0;

  button_debounce_long_press u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .button_levels_i    (button_levels_i),
    .falling_edges_i    (falling_edges_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .short_press_mask_o (short_press_mask_o),
    .long_press_mask_o  (long_press_mask_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // Ticks waiting to be offered, and press masks waiting to be seen.
  tick_t  tick_q[$];
  press_t press_exp_q[$];

  // Our own copy of the register file and the per-button timers.
  logic [AW-1:0] deb_ticks;
  logic [AW-1:0] lp_ticks;
  logic [NB-1:0] lp_enable;
  logic          pend_armed [NB];
  logic [AW-1:0] pend_age   [NB];
  logic          holding    [NB];
  logic [AW-1:0] held_age   [NB];

  // Traffic shaping knobs, set by the sequencer below.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          send_pause     = 1'b0;
  bit          long_stall_req = 1'b0;
  int          stall_left     = 0;

  // Handshake flags captured at the rising edge and read at the falling edge.
  bit          in_fire   = 1'b0;
  int unsigned cfg_seen  = 0;
  int unsigned err_cnt   = 0;

  // Per-button press scripts of the random stimulus generator.
  int          press_left [NB];
  tick_t       next_tick;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Saturating increment of a timer age.
  function automatic logic [AW-1:0] age_step(input logic [AW-1:0] a);
    return (a == AW'(AGEMAX)) ? a : a + 1'b1;
  endfunction

  function automatic void reset_timers();
    deb_ticks = DebounceTicksRst;
    lp_ticks  = LongPressTicksRst;
    lp_enable = '1;
    for (int b = 0; b < NB; b++) begin
      pend_armed[b] = 1'b0;
      pend_age[b]   = '0;
      holding[b]    = 1'b0;
      held_age[b]   = '0;
      press_left[b] = 0;
    end
  endfunction

  function automatic void apply_reg(input logic [CfgIndexWidth-1:0] idx,
                                    input logic [CfgDataWidth-1:0] data);
    case (idx)
      CFG_DEBOUNCE_TICKS:    deb_ticks = data;
      CFG_LONG_PRESS_TICKS:  lp_ticks  = data;
      CFG_LONG_PRESS_ENABLE: lp_enable = data[NB-1:0];
      default: ;
    endcase
  endfunction

  // Advances every button by one tick and returns the press masks it raises.
  // Ages move first, then an edge re-arms the pending timer, then either the
  // hold is checked or, with no hold running, a ripe pending timer is resolved.
  function automatic press_t decode_tick(input tick_t t);
    press_t r;
    r = '0;
    for (int b = 0; b < NB; b++) begin
      if (pend_armed[b]) pend_age[b] = age_step(pend_age[b]);
      if (holding[b]) held_age[b] = age_step(held_age[b]);
      if (t.edges[b]) begin
        pend_armed[b] = 1'b1;
        pend_age[b]   = '0;
      end
      if (holding[b]) begin
        if (held_age[b] >= lp_ticks) begin
          holding[b]  = 1'b0;
          r.long_m[b] = 1'b1;
        end else if (t.levels[b]) begin
          holding[b]   = 1'b0;
          r.short_m[b] = 1'b1;
        end
      end else if (pend_armed[b] && pend_age[b] >= deb_ticks) begin
        pend_armed[b] = 1'b0;
        if (!t.levels[b]) begin
          if (lp_enable[b]) begin
            holding[b]  = 1'b1;
            held_age[b] = pend_age[b];
          end else begin
            r.short_m[b] = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // Rising edge: check the result transaction against the oldest expectation,
  // track register writes, and predict the masks of every accepted tick. The
  // check comes first, since a result taken now always belongs to an older tick.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (press_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("tb: result at %0t with nothing expected: short %h long %h",
                     $time, short_press_mask_o, long_press_mask_o);
        end else begin
          press_t want;
          want = press_exp_q.pop_front();
          if (short_press_mask_o !== want.short_m || long_press_mask_o !== want.long_m) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("tb: mismatch at %0t: short exp %h got %h, long exp %h got %h",
                       $time, want.short_m, short_press_mask_o, want.long_m,
                       long_press_mask_o);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg(cfg_index_i, cfg_wdata_i);
        cfg_seen++;
      end
      if (in_valid_i && in_ready_o)
        press_exp_q.push_back(decode_tick('{levels: button_levels_i,
                                             edges: falling_edges_i}));
      in_fire = in_valid_i && in_ready_o;
    end
  end

  // Tick driver. A transaction already on the bus stays put until it has been
  // accepted; only then may the next one be offered, or the bus go idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (tick_q.size() != 0 && !send_pause && $urandom_range(99) >= send_idle_pct) begin
        next_tick = tick_q.pop_front();
        in_valid_i      <= 1'b1;
        button_levels_i <= next_tick.levels;
        falling_edges_i <= next_tick.edges;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver. A requested long hold-off is counted down here, which
  // lets the output register fill and the input channel back up behind it.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = 80;
        out_ready_i   <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataWidth-1:0] val);
    int unsigned seen;
    @(negedge clk_i);
    seen = cfg_seen;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    while (cfg_seen == seen) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] deb, input logic [15:0] lpt,
                          input logic [15:0] ena);
    write_reg(CFG_DEBOUNCE_TICKS, deb);
    write_reg(CFG_LONG_PRESS_TICKS, lpt);
    write_reg(CFG_LONG_PRESS_ENABLE, ena);
  endtask

  // Waits until every tick has been taken and every result has come back, then
  // a few more cycles so that the block is surely idle before a register write.
  task automatic drain_all();
    while (tick_q.size() != 0 || in_valid_i || press_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_ticks(input logic [NB-1:0] lv, input logic [NB-1:0] ed,
                            input int n);
    repeat (n) tick_q.push_back('{levels: lv, edges: ed});
  endtask

  // Mostly well-formed presses of random length per button, with the odd
  // bounce while held, and a sprinkling of ticks that are pure noise.
  task automatic queue_random_ticks(input int n);
    int            dmax;
    logic [NB-1:0] lv;
    logic [NB-1:0] ed;
    dmax = ((deb_ticks > 20) ? 20 : int'(deb_ticks))
         + ((lp_ticks > 30) ? 30 : int'(lp_ticks)) + 4;
    repeat (n) begin
      lv = '1;
      ed = '0;
      if ($urandom_range(99) < 8) begin
        lv = NB'($urandom);
        ed = NB'($urandom);
      end else begin
        for (int b = 0; b < NB; b++) begin
          if (press_left[b] > 0) begin
            lv[b] = 1'b0;
            ed[b] = ($urandom_range(99) < 4);
            press_left[b]--;
          end else if ($urandom_range(99) < 12) begin
            lv[b] = 1'b0;
            ed[b] = 1'b1;
            press_left[b] = int'($urandom_range(dmax));
          end else begin
            ed[b] = ($urandom_range(99) < 2);
          end
        end
      end
      tick_q.push_back('{levels: lv, edges: ed});
    end
  endtask

  task automatic set_traffic(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  initial begin
    logic [15:0] deb;
    logic [15:0] lpt;
    reset_timers();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Register defaults: all buttons pressed long enough to pass the default
    // debounce time and start holds, then released for short presses.
    push_ticks('0, '1, 1);
    push_ticks('0, '0, 52);
    push_ticks('1, '0, 2);
    drain_all();

    // Directed ticks with short timers and a mixed enable mask; the upper bits
    // of the enable write must be ignored.
    set_regs(16'd2, 16'd4, 16'hFFF5);
    push_ticks('1, '0, 1);
    push_ticks('0, '1, 1);
    push_ticks('0, '0, 3);
    // Edge during hold: buttons 0 and 2 are holding and bounce again.
    push_ticks('0, 4'b0101, 1);
    push_ticks('0, '0, 2);
    // Release before sampling: the pending marks lapse without a report.
    push_ticks('1, '1, 1);
    push_ticks('1, '0, 3);
    // A hold cut short by release reports a short press.
    push_ticks('0, '1, 1);
    push_ticks('0, '0, 2);
    push_ticks('1, '0, 2);
    drain_all();

    // Zero debounce resolves on the edge tick; a zero long-press time still
    // lets a new hold live for one tick.
    set_regs(16'd0, 16'd0, 16'h000A);
    push_ticks(4'b1100, 4'b0011, 1);
    push_ticks(4'b0000, 4'b1100, 1);
    push_ticks('0, '0, 1);
    push_ticks('1, '0, 1);
    drain_all();

    // Random phases, one per traffic pattern and then again, each with its
    // own register setting; a few settings sit at the extremes.
    for (int ph = 0; ph < 8; ph++) begin
      deb = 16'($urandom_range(6));
      lpt = 16'($urandom_range(15));
      if (ph == 3) deb = 16'hFFFF;
      if (ph == 5) begin deb = 16'd1; lpt = 16'hFFFF; end
      if (ph == 6) begin deb = 16'd0; lpt = 16'd0; end
      set_regs(deb, lpt, 16'($urandom));
      set_traffic(ph % 4);
      if (ph == 1) begin
        // Stop offering mid-phase until the block has handed back everything.
        queue_random_ticks(120);
        while (tick_q.size() != 0) @(posedge clk_i);
        send_pause = 1'b1;
        while (in_valid_i || press_exp_q.size() != 0) @(posedge clk_i);
        send_pause = 1'b0;
        queue_random_ticks(120);
      end else begin
        queue_random_ticks(240);
        if (ph == 4) long_stall_req = 1'b1;
      end
      drain_all();
    end

    repeat (6) @(posedge clk_i);
    if (err_cnt == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of every phase above.
  initial begin
    #(30_000_000);
    $display("tb: done, errors");
    $finish;
  end

endmodule
